>>> rtl/core/tcpg_pkg.sv
// Shared types, constants and colour helpers for the test chart pixel generator.
package tcpg_pkg;

  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;
  localparam int NUM_W   = 21;   // pixel * chart span, 4095*320 < 2^21
  localparam int Q_W     = 9;    // chart coordinate, 0..319
  localparam int CELL_W  = 4;    // grid column / row

  localparam logic [NUM_W-1:0] CHART_W = NUM_W'(320);
  localparam logic [NUM_W-1:0] CHART_H = NUM_W'(180);
  localparam logic [Q_W-1:0]   CHART_X_MAX = Q_W'(319);
  localparam logic [Q_W-1:0]   CHART_Y_MAX = Q_W'(179);

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(320);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(180);

  // register indexes on the write port
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // x/20 for x < 320 as (x*205) >> 12
  localparam int CELL_RECIP = 205;
  localparam int CELL_SHIFT = 12;
  localparam int RECIP_W    = 17;

  // pipeline layout
  localparam int DIV_BITS   = Q_W;           // one quotient bit per stage
  localparam int DIV_STAGES = DIV_BITS + 2;  // overflow check, bits, saturate
  localparam int COL_STAGES = 3;
  localparam int NUM_STAGES = 1 + DIV_STAGES + COL_STAGES;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_out_t;

  function automatic pix_out_t skin_tone(input logic [1:0] idx);
    pix_out_t c;
    case (idx)
      2'd0:    c = '{red: 8'd234, green: 8'd189, blue: 8'd157};
      2'd1:    c = '{red: 8'd185, green: 8'd128, blue: 8'd96};
      2'd2:    c = '{red: 8'd121, green: 8'd78,  blue: 8'd55};
      default: c = '{red: 8'd242, green: 8'd204, blue: 8'd177};
    endcase
    return c;
  endfunction

  function automatic logic [7:0] times85(input logic [1:0] v);
    return 8'(v) * 8'd85;
  endfunction

endpackage

>>> rtl/core/tcpg_div.sv
// Pipelined restoring divider for one chart axis, one quotient bit per stage.
module tcpg_div (
  input  logic                                 clk,
  input  logic [tcpg_pkg::DIV_STAGES-1:0]      en,
  input  logic [tcpg_pkg::NUM_W-1:0]           num,
  input  logic [tcpg_pkg::DIM_W-1:0]           dim,
  input  logic [tcpg_pkg::Q_W-1:0]             sat_max,
  output logic [tcpg_pkg::Q_W-1:0]             quo
);

  localparam int NB = tcpg_pkg::DIV_BITS;

  logic [tcpg_pkg::NUM_W-1:0] rem_a [0:NB];
  logic [tcpg_pkg::Q_W-1:0]   q_a   [0:NB];
  logic                       ovf_a [0:NB];

  // quotient would reach 2^Q_W (or divisor is zero): saturate later
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_a[0] <= num;
      q_a[0]   <= '0;
      ovf_a[0] <= {1'b0, num} >= {dim, {tcpg_pkg::Q_W{1'b0}}};
    end
  end

  for (genvar j = 1; j <= NB; j++) begin : g_bit
    localparam int K = NB - j;
    logic [tcpg_pkg::NUM_W-1:0] trial;
    logic                       take;

    always_comb begin
      trial = tcpg_pkg::NUM_W'(dim) << K;
      take  = !ovf_a[j-1] && (rem_a[j-1] >= trial);
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_a[j] <= take ? rem_a[j-1] - trial : rem_a[j-1];
        q_a[j]   <= take ? q_a[j-1] | (tcpg_pkg::Q_W'(1) << K) : q_a[j-1];
        ovf_a[j] <= ovf_a[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NB+1]) begin
      quo <= (ovf_a[NB] || q_a[NB] > sat_max) ? sat_max : q_a[NB];
    end
  end

endmodule

>>> rtl/core/tcpg_color.sv
// Chart cell decode and colour selection, three register stages.
module tcpg_color (
  input  logic                                 clk,
  input  logic [tcpg_pkg::COL_STAGES-1:0]      en,
  input  logic [tcpg_pkg::Q_W-1:0]             cx,
  input  logic [tcpg_pkg::Q_W-1:0]             cy,
  output tcpg_pkg::pix_out_t                   rgb
);

  // stage 0: cell, offsets from circle centre, square and line flags
  logic [tcpg_pkg::CELL_W-1:0] col0, row0;
  logic signed [9:0]           dx0, dy0;
  logic                        mark0;

  logic [tcpg_pkg::RECIP_W-1:0] px, py;
  always_comb begin
    px = tcpg_pkg::RECIP_W'(cx) * tcpg_pkg::RECIP_W'(tcpg_pkg::CELL_RECIP);
    py = tcpg_pkg::RECIP_W'(cy) * tcpg_pkg::RECIP_W'(tcpg_pkg::CELL_RECIP);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      col0  <= tcpg_pkg::CELL_W'(px >> tcpg_pkg::CELL_SHIFT);
      row0  <= tcpg_pkg::CELL_W'(py >> tcpg_pkg::CELL_SHIFT);
      dx0   <= $signed({1'b0, cx}) - 10'sd64;
      dy0   <= $signed({1'b0, cy}) - 10'sd150;
      mark0 <= (cx > 9'd210 && cx < 9'd235 && cy > 9'd130 && cy < 9'd160) ||
               (cx == 9'd160);
    end
  end

  // stage 1: squares
  logic [tcpg_pkg::CELL_W-1:0] col1, row1;
  logic [15:0]                 dx2, dy2;
  logic                        mark1;
  logic signed [19:0]          sqx, sqy;

  always_comb begin
    sqx = 20'(dx0) * 20'(dx0);
    sqy = 20'(dy0) * 20'(dy0);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      col1  <= col0;
      row1  <= row0;
      dx2   <= 16'(sqx);
      dy2   <= 16'(sqy);
      mark1 <= mark0;
    end
  end

  // stage 2: colour
  tcpg_pkg::pix_out_t c;
  logic               white;
  logic [1:0]         band;

  always_comb begin
    white = mark1 || ((17'(dx2) + 17'(dy2)) < 17'd180);
    band  = 2'(row1 - tcpg_pkg::CELL_W'(2));
    case (row1)
      4'd0: begin
        c.red   = 8'(col1) * 8'd17;
        c.green = 8'(col1) * 8'd17;
        c.blue  = 8'(col1) * 8'd17;
      end
      4'd1: c = tcpg_pkg::skin_tone(col1[1:0]);
      4'd2, 4'd3, 4'd4, 4'd5: begin
        c.red   = tcpg_pkg::times85(col1[1:0]);
        c.green = tcpg_pkg::times85(col1[3:2]);
        c.blue  = tcpg_pkg::times85(band);
      end
      default: begin
        c.red   = white ? 8'd255 : 8'd20;
        c.green = white ? 8'd255 : 8'd20;
        c.blue  = white ? 8'd255 : 8'd20;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rgb <= c;
    end
  end

endmodule

>>> rtl/core/test_chart_pixel_generator.sv
// Top level of the test chart pixel generator: handshake, config and pipeline.
//
// Usage:
//   pix channel   : one frame coordinate per transfer (pix_valid high, pix_stall low).
//   rgb channel   : one 8-bit RGB chart colour per accepted coordinate, in order.
//   write port    : wr_en with wr_index 0 = frame_width, 1 = frame_height (13 bits).
//                   Write only while no pixel is in flight.
// Throughput: one pixel per cycle while rgb_stall is low, set by the fully pipelined
//   per-axis divider (one quotient bit per stage).
// Pipeline: 15 register stages: input scaling (1), overflow check (1),
//   9 quotient-bit stages, saturation (1), colour (3). rgb_valid is the valid
//   bit of the last stage.
// Stall: each stage has its own valid bit and moves when the next stage is free,
//   so bubbles close up behind a stalled rgb output; pix_stall rises only when
//   every stage holds a pixel. Nothing is lost or repeated.
// Reset (rst, synchronous): empties the pipeline and restores 320 x 180.
module test_chart_pixel_generator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pix_valid,
  output logic                          pix_stall,
  input  tcpg_pkg::pix_in_t             pix,
  output logic                          rgb_valid,
  input  logic                          rgb_stall,
  output tcpg_pkg::pix_out_t            rgb,
  input  logic                          wr_en,
  input  logic                          wr_index,
  input  logic [tcpg_pkg::DIM_W-1:0]    wr_data
);

  localparam int NS = tcpg_pkg::NUM_STAGES;
  localparam int DS = tcpg_pkg::DIV_STAGES;

  // config registers
  logic [tcpg_pkg::DIM_W-1:0] frame_width, frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= tcpg_pkg::WIDTH_RESET;
      frame_height <= tcpg_pkg::HEIGHT_RESET;
    end else if (wr_en) begin
      case (wr_index)
        tcpg_pkg::REG_FRAME_WIDTH:  frame_width  <= wr_data;
        tcpg_pkg::REG_FRAME_HEIGHT: frame_height <= wr_data;
        default: ;
      endcase
    end
  end

  // per-stage valid and advance; a stage loads when empty or when it drains
  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !vld[NS-1] || !rgb_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= pix_valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign pix_stall = !en[0];
  assign rgb_valid = vld[NS-1];

  // stage 0: scale numerators, pixel * chart span
  logic [tcpg_pkg::NUM_W-1:0] num_x, num_y;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      num_x <= tcpg_pkg::NUM_W'(pix.pixel_x) * tcpg_pkg::CHART_W;
      num_y <= tcpg_pkg::NUM_W'(pix.pixel_y) * tcpg_pkg::CHART_H;
    end
  end

  // stages 1..DS: chart coordinate = numerator / frame size, saturated
  logic [tcpg_pkg::Q_W-1:0] cx, cy;

  tcpg_div u_div_x (
    .clk     (clk),
    .en      (en[DS:1]),
    .num     (num_x),
    .dim     (frame_width),
    .sat_max (tcpg_pkg::CHART_X_MAX),
    .quo     (cx)
  );

  tcpg_div u_div_y (
    .clk     (clk),
    .en      (en[DS:1]),
    .num     (num_y),
    .dim     (frame_height),
    .sat_max (tcpg_pkg::CHART_Y_MAX),
    .quo     (cy)
  );

  // last stages: grid cell and colour, final stage is the output register
  tcpg_color u_color (
    .clk (clk),
    .en  (en[NS-1:DS+1]),
    .cx  (cx),
    .cy  (cy),
    .rgb (rgb)
  );

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the test chart pixel generator.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcpg_pkg::*;

  // Register stages between the pix input and the rgb output.
  localparam int LATENCY = 15;
  // Pixels per random phase; 11 phases give about 550 pixels.
  localparam int PHASE_PIXELS = 50;
  localparam int NUM_PHASES = 11;

  // Keeps its own copy of the frame size, predicts the chart colour of
  // every accepted pixel and matches results in order against it.
  class chart_color_board;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    pix_out_t tone_tab[4];
    pix_out_t expected_rgb[$];
    int mismatches;
    int pixels_sent;
    int colors_checked;

    function new();
      width = 13'd320;
      height = 13'd180;
      tone_tab[0] = '{red: 8'd234, green: 8'd189, blue: 8'd157};
      tone_tab[1] = '{red: 8'd185, green: 8'd128, blue: 8'd96};
      tone_tab[2] = '{red: 8'd121, green: 8'd78,  blue: 8'd55};
      tone_tab[3] = '{red: 8'd242, green: 8'd204, blue: 8'd177};
      mismatches = 0;
      pixels_sent = 0;
      colors_checked = 0;
    endfunction

    function void set_reg(logic idx, logic [DIM_W-1:0] data);
      if (idx == REG_FRAME_WIDTH) begin
        width = data;
      end else begin
        height = data;
      end
    endfunction

    // Truncating scale onto the chart; zero size and overflow both pin
    // the position to the last chart point.
    function int unsigned chart_pos(int unsigned pos, int unsigned span,
                                    int unsigned dim);
      int unsigned v;
      if (dim == 0) return span - 1;
      v = (pos * span) / dim;
      if (v > span - 1) v = span - 1;
      return v;
    endfunction

    function pix_out_t chart_color(pix_in_t p);
      logic [8:0] cx;
      logic [8:0] cy;
      logic [3:0] col;
      logic [3:0] row;
      int dx;
      int dy;
      pix_out_t c;
      cx = 9'(chart_pos(32'(p.pixel_x), 32'd320, 32'(width)));
      cy = 9'(chart_pos(32'(p.pixel_y), 32'd180, 32'(height)));
      col = 4'(cx / 20);
      row = 4'(cy / 20);
      c = '{red: 8'd20, green: 8'd20, blue: 8'd20};
      if (row == 0) begin
        c.red = 8'(col) * 8'd17;
        c.green = c.red;
        c.blue = c.red;
      end else if (row == 1) begin
        c = tone_tab[col[1:0]];
      end else if (row <= 5) begin
        c.red = 8'(col[1:0]) * 8'd85;
        c.green = 8'(col[3:2]) * 8'd85;
        c.blue = 8'(row - 4'd2) * 8'd85;
      end else begin
        // lower rows: circle, square and centre line in white
        dx = int'(cx) - 64;
        dy = int'(cy) - 150;
        if (dx * dx + dy * dy < 180 ||
            (cx > 210 && cx < 235 && cy > 130 && cy < 160) || cx == 160) begin
          c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
        end
      end
      return c;
    endfunction

    function void note_pixel(pix_in_t p);
      expected_rgb.push_back(chart_color(p));
      pixels_sent++;
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_rgb(pix_out_t got);
      pix_out_t want;
      if (expected_rgb.size() == 0) begin
        $display("%0t: unexpected rgb transfer, expected none actual %h",
                 $time, got);
        mismatches++;
        return;
      end
      want = expected_rgb.pop_front();
      colors_checked++;
      check_field("red", want.red, got.red);
      check_field("green", want.green, got.green);
      check_field("blue", want.blue, got.blue);
    endfunction

    function int pending();
      return expected_rgb.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pix_valid = 1'b0;
  logic pix_stall;
  pix_in_t pix = '0;
  logic rgb_valid;
  logic rgb_stall = 1'b0;
  pix_out_t rgb;
  logic wr_en = 1'b0;
  logic wr_index = REG_FRAME_WIDTH;
  logic [DIM_W-1:0] wr_data = '0;

  chart_color_board board = new();

  // sender burst bookkeeping
  int burst_left = 0;
  // receiver stall pattern: mode and how long it lasts
  int stall_mode = 0;
  int mode_left = 0;

  test_chart_pixel_generator uut (
    .clk(clk),
    .rst(rst),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix(pix),
    .rgb_valid(rgb_valid),
    .rgb_stall(rgb_stall),
    .rgb(rgb),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Output side: check every rgb transfer, then pick next cycle's stall.
  // Modes: never stall, light stall, heavy stall, alternating.
  always @(posedge clk) begin
    if (!rst && rgb_valid && !rgb_stall) begin
      board.check_rgb(rgb);
    end
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left <= $urandom_range(8, 80);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: rgb_stall <= 1'b0;
      1: rgb_stall <= ($urandom_range(0, 3) == 0);
      2: rgb_stall <= ($urandom_range(0, 3) != 0);
      default: rgb_stall <= ~rgb_stall;
    endcase
  end

  // One pixel transfer. Bursts of random length; between bursts valid
  // drops for a random gap (sometimes none, so bursts run back to back).
  task automatic send_pixel(input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y);
    int gap;
    pix_in_t p;
    p.pixel_x = x;
    p.pixel_y = y;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        pix_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pix <= p;
    pix_valid <= 1'b1;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    board.note_pixel(p);
  endtask

  // Let every expected colour come back, then let the pipe run dry.
  task automatic drain();
    pix_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Writes both frame registers; only called with the pipe empty.
  task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    wr_en <= 1'b1;
    wr_index <= REG_FRAME_WIDTH;
    wr_data <= w;
    @(posedge clk);
    board.set_reg(REG_FRAME_WIDTH, w);
    wr_index <= REG_FRAME_HEIGHT;
    wr_data <= h;
    @(posedge clk);
    board.set_reg(REG_FRAME_HEIGHT, h);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Highest coordinate still inside a frame of the given size; 4095 for a zero size.
  function automatic logic [COORD_W-1:0] last_in_frame(logic [DIM_W-1:0] dim);
    if (dim == 0 || dim > 13'd4096) return 12'd4095;
    return COORD_W'(dim - 13'd1);
  endfunction

  // Frame sizes per phase: reset size, zero, one, the nominal max, the all-ones
  // register value, common video sizes and 17 x 0; the last three random.
  logic [DIM_W-1:0] phase_w[NUM_PHASES] =
    '{13'd320, 13'd0, 13'd1, 13'd4096, 13'd8191, 13'd640, 13'd1920, 13'd17,
      13'd0, 13'd0, 13'd0};
  logic [DIM_W-1:0] phase_h[NUM_PHASES] =
    '{13'd180, 13'd4096, 13'd1, 13'd4096, 13'd8191, 13'd360, 13'd1080, 13'd0,
      13'd0, 13'd0, 13'd0};

  initial begin
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset frame 320x180 so the chart position is the pixel.
    send_pixel(12'd0, 12'd0);        // gray ramp, black
    send_pixel(12'd319, 12'd0);      // gray ramp, white end
    send_pixel(12'd0, 12'd20);       // first skin tone
    send_pixel(12'd60, 12'd39);      // last skin tone
    send_pixel(12'd100, 12'd60);     // colour cube
    send_pixel(12'd319, 12'd119);    // colour cube corner
    send_pixel(12'd51, 12'd150);     // just inside circle
    send_pixel(12'd50, 12'd150);     // just outside circle
    send_pixel(12'd211, 12'd131);    // square corner
    send_pixel(12'd210, 12'd131);    // beside square
    send_pixel(12'd160, 12'd125);    // centre line
    send_pixel(12'd300, 12'd170);    // dark gray background
    send_pixel(12'd4095, 12'd4095);  // far outside frame, saturates
    send_pixel(12'd320, 12'd180);    // first pixel past the frame
    drain();

    // Zero frame size pins the chart to its last point.
    set_frame(13'd0, 13'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    drain();

    // Register value above the nominal max, all bits set.
    set_frame(13'd8191, 13'd8191);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2048, 12'd0);
    drain();

    // One-pixel frame: pixel 0 maps to the origin, anything else saturates.
    set_frame(13'd1, 13'd1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd0, 12'd1);
    drain();

    // Random phases. Most pixels fall inside the frame so every chart
    // region is reached; a fifth span the full coordinate range.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph >= NUM_PHASES - 3) begin
        w = DIM_W'($urandom_range(1, 4096));
        h = DIM_W'($urandom_range(1, 4096));
      end else begin
        w = phase_w[ph];
        h = phase_h[ph];
      end
      set_frame(w, h);
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          x = COORD_W'($urandom_range(0, 4095));
          y = COORD_W'($urandom_range(0, 4095));
        end else begin
          x = COORD_W'($urandom_range(0, 32'(last_in_frame(w))));
          y = COORD_W'($urandom_range(0, 32'(last_in_frame(h))));
        end
        send_pixel(x, y);
      end
      drain();
    end

    if (board.pending() != 0) begin
      $display("%0t: %0d colours expected but never seen", $time, board.pending());
      board.mismatches++;
    end

    $display("sent %0d pixels, checked %0d colours over %0d frame sizes",
             board.pixels_sent, board.colors_checked, NUM_PHASES + 4);
    $display("frame sizes included zero, one, 4096 and 8191; %0d mismatches",
             board.mismatches);
    if (board.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: the run of roughly 600 pixels plus drains ends well before this timeout.
  initial begin
    #500us;
    $display("%0t: timeout with %0d colours outstanding", $time, board.pending());
    $display("status: fail");
    $finish;
  end

endmodule
